// File: rtl/ffsa_pkg.sv
// Shared types, codes and default sizes for the first-fit segment allocator.
`timescale 1ns / 1ps

package ffsa_pkg;

  // Default sizes of the word memory and the segment slot table.
  localparam int MEM_WORDS_DEF    = 128;
  localparam int MAX_SEGMENTS_DEF = 16;

  // Fixed field widths of the transaction ports.
  localparam int OP_W     = 2;
  localparam int SIZE_W   = 8;
  localparam int HANDLE_W = 4;
  localparam int POS_W    = 8;
  localparam int WORD_W   = 32;
  localparam int STATUS_W = 3;
  localparam int BASE_W   = 7;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_WRITE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NOMEM     = 3'd1,
    ST_NOSLOT    = 3'd2,
    ST_BADHANDLE = 3'd3,
    ST_BADPOS    = 3'd4
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    capture;
    logic    clr_write;
    logic    alloc_init;
    logic    pass_init;
    logic    scan_issue;
    logic    advance;
    logic    alloc_commit;
    logic    slot_rd_handle;
    logic    free_commit;
    logic    word_write;
    logic    word_read;
    logic    res_load;
    logic    res_alloc;
    logic    res_read;
    status_t res_status;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    op_t  op;
    logic size_zero;
    logic clr_last;
    logic scan_last;
    logic fits;
    logic found_next;
    logic free_found;
    logic h_bad;
    logic pos_bad;
  } sts_t;

endpackage

// File: rtl/ffsa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module ffsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/ffsa_ctrl.sv
// Controller state machine of the first-fit segment allocator.
`timescale 1ns / 1ps

module ffsa_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  output logic          busy,
  output logic          done,
  output ffsa_pkg::cmd_t cmd,
  input  ffsa_pkg::sts_t sts
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_DRAIN,
    S_DECIDE,
    S_HREAD,
    S_RWAIT
  } state_t;

  state_t state, state_next;
  logic   busy_next;
  logic   done_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    busy_next  = busy;
    done_next  = 1'b0;
    case (state)
      S_CLEAR: begin
        cmd.clr_write = 1'b1;
        if (sts.clr_last) begin
          state_next = S_IDLE;
          busy_next  = 1'b0;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
          busy_next   = 1'b1;
        end
      end
      S_DISPATCH: begin
        if (sts.op == ffsa_pkg::OP_ALLOC) begin
          if (sts.size_zero) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = ffsa_pkg::ST_NOMEM;
            done_next      = 1'b1;
            busy_next      = 1'b0;
            state_next     = S_IDLE;
          end else begin
            cmd.alloc_init = 1'b1;
            cmd.pass_init  = 1'b1;
            state_next     = S_SCAN;
          end
        end else if (sts.h_bad) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ffsa_pkg::ST_BADHANDLE;
          done_next      = 1'b1;
          busy_next      = 1'b0;
          state_next     = S_IDLE;
        end else if (sts.op == ffsa_pkg::OP_FREE) begin
          cmd.free_commit = 1'b1;
          cmd.res_load    = 1'b1;
          cmd.res_status  = ffsa_pkg::ST_OK;
          done_next       = 1'b1;
          busy_next       = 1'b0;
          state_next      = S_IDLE;
        end else begin
          cmd.slot_rd_handle = 1'b1;
          state_next         = S_HREAD;
        end
      end
      S_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if (sts.fits) begin
          cmd.res_load = 1'b1;
          done_next    = 1'b1;
          busy_next    = 1'b0;
          state_next   = S_IDLE;
          if (sts.free_found) begin
            cmd.alloc_commit = 1'b1;
            cmd.res_alloc    = 1'b1;
            cmd.res_status   = ffsa_pkg::ST_OK;
          end else begin
            cmd.res_status = ffsa_pkg::ST_NOSLOT;
          end
        end else if (!sts.found_next) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ffsa_pkg::ST_NOMEM;
          done_next      = 1'b1;
          busy_next      = 1'b0;
          state_next     = S_IDLE;
        end else begin
          cmd.advance   = 1'b1;
          cmd.pass_init = 1'b1;
          state_next    = S_SCAN;
        end
      end
      S_HREAD: begin
        if (sts.pos_bad) begin
          cmd.res_load   = 1'b1;
          cmd.res_status = ffsa_pkg::ST_BADPOS;
          done_next      = 1'b1;
          busy_next      = 1'b0;
          state_next     = S_IDLE;
        end else if (sts.op == ffsa_pkg::OP_WRITE) begin
          cmd.word_write = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_status = ffsa_pkg::ST_OK;
          done_next      = 1'b1;
          busy_next      = 1'b0;
          state_next     = S_IDLE;
        end else begin
          cmd.word_read = 1'b1;
          state_next    = S_RWAIT;
        end
      end
      S_RWAIT: begin
        cmd.res_load   = 1'b1;
        cmd.res_read   = 1'b1;
        cmd.res_status = ffsa_pkg::ST_OK;
        done_next      = 1'b1;
        busy_next      = 1'b0;
        state_next     = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
        busy_next  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      busy  <= 1'b1;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= busy_next;
      done  <= done_next;
    end
  end

endmodule

// File: rtl/ffsa_dp.sv
// Datapath of the first-fit segment allocator: slot table, word store, gap search.
`timescale 1ns / 1ps

module ffsa_dp #(
  parameter int MEM_WORDS    = ffsa_pkg::MEM_WORDS_DEF,
  parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ffsa_pkg::cmd_t                      cmd,
  output ffsa_pkg::sts_t                      sts,
  input  logic [ffsa_pkg::OP_W-1:0]           operation,
  input  logic [ffsa_pkg::SIZE_W-1:0]         request_size,
  input  logic [ffsa_pkg::HANDLE_W-1:0]       handle,
  input  logic [ffsa_pkg::POS_W-1:0]          position,
  input  logic signed [ffsa_pkg::WORD_W-1:0]  write_value,
  output logic [ffsa_pkg::STATUS_W-1:0]       status,
  output logic [ffsa_pkg::HANDLE_W-1:0]       handle_out,
  output logic [ffsa_pkg::BASE_W-1:0]         base_out,
  output logic signed [ffsa_pkg::WORD_W-1:0]  read_value
);

  localparam int AW  = $clog2(MEM_WORDS);
  localparam int CW  = AW + 1;
  localparam int SW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int HW  = ((SW > ffsa_pkg::HANDLE_W) ? SW : ffsa_pkg::HANDLE_W) + 1;
  localparam int LW  = (CW > ffsa_pkg::SIZE_W) ? CW : ffsa_pkg::SIZE_W;
  localparam int AD  = ((AW > ffsa_pkg::POS_W) ? AW : ffsa_pkg::POS_W) + 1;
  localparam int BW  = (CW > ffsa_pkg::BASE_W) ? CW : ffsa_pkg::BASE_W;
  localparam int SDW = AW + ffsa_pkg::SIZE_W;

  // Captured request.
  ffsa_pkg::op_t                   op_q;
  logic [ffsa_pkg::SIZE_W-1:0]     size_q;
  logic [ffsa_pkg::HANDLE_W-1:0]   handle_q;
  logic [ffsa_pkg::POS_W-1:0]      pos_q;
  logic [ffsa_pkg::WORD_W-1:0]     wval_q;

  // Search and table state.
  logic [AW-1:0]           clr_cnt;
  logic [CW-1:0]           cur;
  logic [SW-1:0]           scan_idx;
  logic                    p_live;
  logic                    p_valid;
  logic [SW-1:0]           p_idx;
  logic                    found_next;
  logic [AW-1:0]           next_base;
  logic [CW-1:0]           next_end;
  logic                    free_found;
  logic [SW-1:0]           free_idx;
  logic [MAX_SEGMENTS-1:0] slot_valid;

  logic [SDW-1:0]                slot_rdata;
  logic [AW-1:0]                 rd_base;
  logic [ffsa_pkg::SIZE_W-1:0]   rd_len;
  logic [CW-1:0]                 p_end;
  logic                          p_hit;
  logic [HW-1:0]                 h_wide;
  logic [SW-1:0]                 h_idx;
  logic [CW-1:0]                 gap_end;
  logic [CW-1:0]                 gap;
  logic [AD-1:0]                 word_addr;
  logic [ffsa_pkg::WORD_W-1:0]   word_rdata;
  logic [BW-1:0]                 cur_wide;
  logic [HW-1:0]                 free_wide;

  logic                  slot_re;
  logic [SW-1:0]         slot_raddr;
  logic                  word_we;
  logic [AW-1:0]         word_waddr;
  logic [ffsa_pkg::WORD_W-1:0] word_wdata;

  assign rd_base = slot_rdata[SDW-1:ffsa_pkg::SIZE_W];
  assign rd_len  = slot_rdata[ffsa_pkg::SIZE_W-1:0];
  assign p_end   = CW'(rd_base) + CW'(rd_len);
  assign p_hit   = p_valid && (CW'(rd_base) >= cur) && (!found_next || rd_base < next_base);

  assign h_wide  = HW'(handle_q);
  assign h_idx   = h_wide[SW-1:0];

  assign gap_end = found_next ? CW'(next_base) : CW'(MEM_WORDS);
  assign gap     = gap_end - cur;

  assign word_addr = AD'(rd_base) + AD'(pos_q) - AD'(1);

  assign cur_wide  = BW'(cur);
  assign free_wide = HW'(free_idx);

  always_comb begin
    sts            = '0;
    sts.op         = op_q;
    sts.size_zero  = (size_q == '0);
    sts.clr_last   = (clr_cnt == AW'(MEM_WORDS - 1));
    sts.scan_last  = (scan_idx == SW'(MAX_SEGMENTS - 1));
    sts.fits       = (LW'(gap) >= LW'(size_q));
    sts.found_next = found_next;
    sts.free_found = free_found;
    sts.h_bad      = (h_wide >= HW'(MAX_SEGMENTS)) || !slot_valid[h_idx];
    sts.pos_bad    = (pos_q == '0) || (pos_q > rd_len) || (word_addr >= AD'(MEM_WORDS));
  end

  // Slot table: base and length of each segment.
  assign slot_re    = cmd.scan_issue | cmd.slot_rd_handle;
  assign slot_raddr = cmd.scan_issue ? scan_idx : h_idx;

  ffsa_ram #(
    .WIDTH (SDW),
    .DEPTH (MAX_SEGMENTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (cmd.alloc_commit),
    .waddr (free_idx),
    .wdata ({cur[AW-1:0], size_q}),
    .re    (slot_re),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  // Word store, zeroed by the clearing pass after reset.
  assign word_we    = cmd.clr_write | cmd.word_write;
  assign word_waddr = cmd.clr_write ? clr_cnt : word_addr[AW-1:0];
  assign word_wdata = cmd.clr_write ? '0 : wval_q;

  ffsa_ram #(
    .WIDTH (ffsa_pkg::WORD_W),
    .DEPTH (MEM_WORDS)
  ) u_word_ram (
    .clk   (clk),
    .we    (word_we),
    .waddr (word_waddr),
    .wdata (word_wdata),
    .re    (cmd.word_read),
    .raddr (word_addr[AW-1:0]),
    .rdata (word_rdata)
  );

  // Captured request, result and search registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q     <= ffsa_pkg::op_t'(operation);
      size_q   <= request_size;
      handle_q <= handle;
      pos_q    <= position;
      wval_q   <= write_value;
    end
    if (cmd.res_load) begin
      status     <= cmd.res_status;
      handle_out <= cmd.res_alloc ? free_wide[ffsa_pkg::HANDLE_W-1:0] : '0;
      base_out   <= cmd.res_alloc ? cur_wide[ffsa_pkg::BASE_W-1:0] : '0;
      read_value <= cmd.res_read ? word_rdata : '0;
    end
    if (cmd.alloc_init) begin
      cur <= '0;
    end else if (cmd.advance) begin
      cur <= next_end;
    end
    if (cmd.pass_init) begin
      scan_idx <= '0;
    end else if (cmd.scan_issue) begin
      scan_idx <= scan_idx + SW'(1);
    end
    if (cmd.scan_issue) begin
      p_valid <= slot_valid[scan_idx];
      p_idx   <= scan_idx;
    end
    if (p_live && p_hit) begin
      next_base <= rd_base;
      next_end  <= p_end;
    end
    if (p_live && !p_valid && !free_found) begin
      free_idx <= p_idx;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      p_live     <= 1'b0;
      found_next <= 1'b0;
      free_found <= 1'b0;
      slot_valid <= '0;
    end else begin
      if (cmd.clr_write) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      p_live <= cmd.scan_issue;
      if (cmd.pass_init) begin
        found_next <= 1'b0;
        free_found <= 1'b0;
      end else if (p_live) begin
        if (p_hit) begin
          found_next <= 1'b1;
        end
        if (!p_valid) begin
          free_found <= 1'b1;
        end
      end
      if (cmd.alloc_commit) begin
        slot_valid[free_idx] <= 1'b1;
      end else if (cmd.free_commit) begin
        slot_valid[h_idx] <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/first_fit_segment_allocator_core.sv
// Top level of the first-fit segment allocator: controller plus datapath.
`timescale 1ns / 1ps

// Channel     Handshake           Payload
// request     start, busy         operation, request_size, handle, position, write_value
// result      done (one cycle)    status, handle_out, base_out, read_value
//
// A request transaction is taken at an edge with start high and busy low; its one result
// transaction shows for the single cycle in which done is high, and the receiver cannot stall
// it. Busy is already low in that cycle, so the next request may be taken at its closing edge.
// Free ends in the dispatch state, write in the handle read state, read in a word wait state.
// An allocate has a dispatch state and one pass (slot scan, drain, decide) per segment below
// the chosen gap plus one, up to MAX_SEGMENTS + 1. After reset busy is high while memory clears.
module first_fit_segment_allocator_core #(
  parameter int MEM_WORDS    = ffsa_pkg::MEM_WORDS_DEF,
  parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic [ffsa_pkg::OP_W-1:0]           operation,
  input  logic [ffsa_pkg::SIZE_W-1:0]         request_size,
  input  logic [ffsa_pkg::HANDLE_W-1:0]       handle,
  input  logic [ffsa_pkg::POS_W-1:0]          position,
  input  logic signed [ffsa_pkg::WORD_W-1:0]  write_value,
  output logic                                done,
  output logic [ffsa_pkg::STATUS_W-1:0]       status,
  output logic [ffsa_pkg::HANDLE_W-1:0]       handle_out,
  output logic [ffsa_pkg::BASE_W-1:0]         base_out,
  output logic signed [ffsa_pkg::WORD_W-1:0]  read_value
);

  // The controller sequences each transaction; the datapath owns all storage.
  ffsa_pkg::cmd_t cmd;
  ffsa_pkg::sts_t sts;

  ffsa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd),
    .sts   (sts)
  );

  // The gap search keeps a current gap start, beginning at address zero. Each pass finds
  // the lowest segment at or above it; if the space up to that segment (or to the end
  // of memory) holds the request, the gap is taken, otherwise the search moves to that
  // segment's end. The same pass records the lowest unused slot for the new handle.
  ffsa_dp #(
    .MEM_WORDS    (MEM_WORDS),
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .operation    (operation),
    .request_size (request_size),
    .handle       (handle),
    .position     (position),
    .write_value  (write_value),
    .status       (status),
    .handle_out   (handle_out),
    .base_out     (base_out),
    .read_value   (read_value)
  );

endmodule
